// ----- rtl/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and constants for the coalesced range set.
// ----------------------------------------------------------------------------
`default_nettype none

package crs_pkg;

	localparam int MAX_RANGES   = 16;
	localparam int IDX_W        = $clog2(MAX_RANGES);
	localparam int CNT_W        = $clog2(MAX_RANGES + 1);
	localparam int NXT_W        = CNT_W + 1;
	localparam int VAL_W        = 64;
	localparam int ENTRY_CNT_W  = 5;

	typedef logic [VAL_W-1:0] val_t;

	typedef enum logic [1:0] {
		REQ_ADD     = 2'd0,
		REQ_REMOVE  = 2'd1,
		REQ_QUERY   = 2'd2,
		REQ_READOUT = 2'd3
	} req_t;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_BAD_SPAN = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_MERGE,
		ST_ADD_BUILD,
		ST_REMOVE,
		ST_QUERY,
		ST_READOUT,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/coalesced_range_set.sv -----
// ----------------------------------------------------------------------------
// coalesced_range_set
// Sorted table of disjoint inclusive 64-bit ranges with add, remove, query
// and readout requests.
// ----------------------------------------------------------------------------
//
//  channel   signals                               direction
//  -------   -----------------------------------   ---------
//  request   in_valid/in_ready, req_type, span_*    in
//  result    out_valid/out_ready, status .. last    out
//
//  Add walks the stored entries twice with one compare unit, remove and
//  query once (query stops at a hit), readout gives one result per entry
//  or a single one when the table holds none. in_ready is high only in
//  idle; a finished result sits in the output register while the next
//  request is taken. A stalled output holds the sequencer only in readout
//  and in the final response step. Reset empties the table at once.
//
`default_nettype none

module coalesced_range_set (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire  [1:0]                 req_type,
	input  wire  crs_pkg::val_t        span_start,
	input  wire  crs_pkg::val_t        span_end,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [1:0]                 status,
	output logic                       is_covered,
	output crs_pkg::val_t              entry_start,
	output crs_pkg::val_t              entry_end,
	output logic [4:0]                 entry_count,
	output logic                       last
);
	import crs_pkg::*;

	localparam val_t TOP_VALUE = '1;

	state_t           state_q, state_d;
	val_t             start_q [2][MAX_RANGES];
	val_t             end_q   [2][MAX_RANGES];
	logic             bank_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] i_q;
	logic [NXT_W-1:0] n_q;
	logic             placed_q;
	logic             cov_q;
	logic [1:0]       stat_q;
	val_t             s_q, e_q, ms_q, me_q;

	logic             out_valid_q, last_q, cov_out_q;
	logic [1:0]       status_q;
	val_t             es_q, ee_q;
	logic [4:0]       count_q;

	val_t             rd_s, rd_e;
	logic             scan_end, cur_join, hit, out_free, rd_last;
	logic             wr0_en, wr1_en, set_placed, commit_try, load;
	val_t             wr0_s, wr0_e, wr1_s, wr1_e;
	logic [1:0]       inc;
	logic [NXT_W-1:0] n_next;
	logic [1:0]       ld_status;
	logic             ld_cov, ld_last;
	val_t             ld_es, ld_ee;
	logic             lo_part, hi_part, inner, outer;

	function automatic logic joinable(val_t a0, val_t a1, val_t b0, val_t b1);
		logic sep_a, sep_b;
		sep_a = (a1 != TOP_VALUE) && ((a1 + 64'd1) < b0);
		sep_b = (b1 != TOP_VALUE) && ((b1 + 64'd1) < a0);
		return !sep_a && !sep_b;
	endfunction

	assign rd_s     = start_q[bank_q][i_q[IDX_W-1:0]];
	assign rd_e     = end_q[bank_q][i_q[IDX_W-1:0]];
	assign scan_end = (i_q == used_q);
	assign cur_join = joinable(rd_s, rd_e, s_q, e_q);
	assign hit      = !scan_end && (s_q >= rd_s) && (e_q <= rd_e);
	assign out_free = !out_valid_q || out_ready;
	assign rd_last  = (used_q == '0) || ((i_q + CNT_W'(1)) == used_q);
	assign n_next   = n_q + NXT_W'(inc);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_READOUT) begin
						state_d = ST_READOUT;
					end else if (span_start > span_end) begin
						state_d = ST_RESP;
					end else if (req_type == REQ_ADD) begin
						state_d = ST_ADD_MERGE;
					end else if (req_type == REQ_REMOVE) begin
						state_d = ST_REMOVE;
					end else begin
						state_d = ST_QUERY;
					end
				end
			end
			ST_ADD_MERGE: if (scan_end) state_d = ST_ADD_BUILD;
			ST_ADD_BUILD: if (scan_end) state_d = ST_RESP;
			ST_REMOVE:    if (scan_end) state_d = ST_RESP;
			ST_QUERY:     if (scan_end || hit) state_d = ST_RESP;
			ST_READOUT:   if (out_free && rd_last) state_d = ST_IDLE;
			ST_RESP:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		wr0_en     = 1'b0;
		wr1_en     = 1'b0;
		wr0_s      = rd_s;
		wr0_e      = rd_e;
		wr1_s      = rd_s;
		wr1_e      = rd_e;
		inc        = 2'd0;
		set_placed = 1'b0;
		commit_try = 1'b0;
		load       = 1'b0;
		ld_status  = stat_q;
		ld_cov     = cov_q;
		ld_es      = '0;
		ld_ee      = '0;
		ld_last    = 1'b1;
		lo_part    = rd_s < s_q;
		hi_part    = rd_e > e_q;
		inner      = (rd_s >= s_q) && (rd_e <= e_q);
		outer      = (rd_e < s_q) || (rd_s > e_q);
		case (state_q)
			ST_ADD_BUILD: begin
				if (!scan_end) begin
					if (!cur_join) begin
						if (!placed_q && rd_s > me_q) begin
							wr0_en     = 1'b1;
							wr0_s      = ms_q;
							wr0_e      = me_q;
							wr1_en     = 1'b1;
							inc        = 2'd2;
							set_placed = 1'b1;
						end else begin
							wr0_en = 1'b1;
							inc    = 2'd1;
						end
					end
				end else begin
					if (!placed_q) begin
						wr0_en = 1'b1;
						wr0_s  = ms_q;
						wr0_e  = me_q;
						inc    = 2'd1;
					end
					commit_try = 1'b1;
				end
			end
			ST_REMOVE: begin
				if (!scan_end) begin
					if (outer) begin
						wr0_en = 1'b1;
						inc    = 2'd1;
					end else if (!inner) begin
						// keep the part below the span and the part above it
						if (lo_part) begin
							wr0_en = 1'b1;
							wr0_e  = s_q - 64'd1;
							if (hi_part) begin
								wr1_en = 1'b1;
								wr1_s  = e_q + 64'd1;
								inc    = 2'd2;
							end else begin
								inc = 2'd1;
							end
						end else if (hi_part) begin
							wr0_en = 1'b1;
							wr0_s  = e_q + 64'd1;
							inc    = 2'd1;
						end
					end
				end else begin
					commit_try = 1'b1;
				end
			end
			ST_READOUT: begin
				load      = out_free;
				ld_status = STAT_OK;
				ld_cov    = 1'b0;
				ld_last   = rd_last;
				if (used_q != '0) begin
					ld_es = rd_s;
					ld_ee = rd_e;
				end
			end
			ST_RESP: begin
				load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bank_q   <= 1'b0;
			used_q   <= '0;
			i_q      <= '0;
			n_q      <= '0;
			placed_q <= 1'b0;
			cov_q    <= 1'b0;
			stat_q   <= STAT_OK;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					i_q      <= '0;
					n_q      <= '0;
					placed_q <= 1'b0;
					cov_q    <= 1'b0;
					stat_q   <= (span_start > span_end) ? STAT_BAD_SPAN : STAT_OK;
				end
				ST_ADD_MERGE: begin
					i_q <= scan_end ? '0 : i_q + CNT_W'(1);
				end
				ST_ADD_BUILD, ST_REMOVE: begin
					if (!scan_end) i_q <= i_q + CNT_W'(1);
					n_q <= n_next;
					if (set_placed) placed_q <= 1'b1;
					if (commit_try) begin
						if (n_next > NXT_W'(MAX_RANGES)) begin
							stat_q <= STAT_OVERFLOW;
						end else begin
							bank_q <= ~bank_q;
							used_q <= n_next[CNT_W-1:0];
						end
					end
				end
				ST_QUERY: begin
					if (!scan_end) i_q <= i_q + CNT_W'(1);
					if (hit) cov_q <= 1'b1;
				end
				ST_READOUT: begin
					if (out_free) i_q <= i_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// request and merge registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			s_q  <= span_start;
			e_q  <= span_end;
			ms_q <= span_start;
			me_q <= span_end;
		end else if (state_q == ST_ADD_MERGE && !scan_end && cur_join) begin
			if (rd_s < ms_q) ms_q <= rd_s;
			if (rd_e > me_q) me_q <= rd_e;
		end
	end

	// new table is built in the idle bank, swapped in on commit
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RANGES; k++) begin
			if (wr0_en && n_q == NXT_W'(k)) begin
				start_q[~bank_q][k] <= wr0_s;
				end_q[~bank_q][k]   <= wr0_e;
			end
			if (wr1_en && (n_q + NXT_W'(1)) == NXT_W'(k)) begin
				start_q[~bank_q][k] <= wr1_s;
				end_q[~bank_q][k]   <= wr1_e;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q  <= ld_status;
			cov_out_q <= ld_cov;
			es_q      <= ld_es;
			ee_q      <= ld_ee;
			count_q   <= ENTRY_CNT_W'(used_q);
			last_q    <= ld_last;
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign is_covered  = cov_out_q;
	assign entry_start = es_q;
	assign entry_end   = ee_q;
	assign entry_count = count_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// ----- rtl/crs_checker.sv -----
// ----------------------------------------------------------------------------
// crs_checker
// Port-level checks on the coalesced range set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire                 out_valid,
	input wire [1:0]           status,
	input wire                 is_covered,
	input wire crs_pkg::val_t  entry_start,
	input wire [4:0]           entry_count,
	input wire                 last
);
	import crs_pkg::*;

	// ready is low in the cycle after a request is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a request");

	// mid-readout no new request is taken
	a_readout_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("request taken during readout");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> last && entry_start == '0 && !is_covered)
		else $error("refused request gave a malformed result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= 5'(MAX_RANGES) && status != 2'd3)
		else $error("result count or status out of range");

endmodule

bind coalesced_range_set crs_checker u_crs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.status      (status),
	.is_covered  (is_covered),
	.entry_start (entry_start),
	.entry_count (entry_count),
	.last        (last)
);

`default_nettype wire

// ----- bench/tb_coalesced_range_set.sv -----
// ----------------------------------------------------------------------------
// tb_coalesced_range_set
// Drives add, remove, query and readout requests into the range set with
// random idling on both channels, predicts every result from a local copy of
// the table and checks each one field by field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

class range_set_scoreboard;
	typedef struct {
		logic [1:0]  status;
		logic        is_covered;
		logic [63:0] entry_start;
		logic [63:0] entry_end;
		logic [4:0]  entry_count;
		logic        last;
	} result_t;

	logic [63:0] lo_tab[crs_pkg::MAX_RANGES];
	logic [63:0] hi_tab[crs_pkg::MAX_RANGES];
	int          n_used;
	result_t     pending[$];
	int          errors;

	function new();
		n_used = 0;
		errors = 0;
	endfunction

	function void push(logic [1:0] st, logic cov, logic [63:0] es, logic [63:0] ee,
			logic lst);
		result_t r;
		r.status = st;
		r.is_covered = cov;
		r.entry_start = es;
		r.entry_end = ee;
		r.entry_count = n_used[4:0];
		r.last = lst;
		pending = {pending, r};
	endfunction

	function bit touches(logic [63:0] a0, logic [63:0] a1, logic [63:0] b0,
			logic [63:0] b1);
		if (a1 != '1 && a1 + 64'd1 < b0) return 0;
		if (b1 != '1 && b1 + 64'd1 < a0) return 0;
		return 1;
	endfunction

	// merged list built in wl/wh, committed only if it fits
	function logic [1:0] merge_in(logic [63:0] s, logic [63:0] e);
		logic [63:0] wl[$], wh[$];
		logic [63:0] ms, me;
		bit placed;
		placed = 0;
		ms = s;
		me = e;
		for (int i = 0; i < n_used; i++)
			if (touches(lo_tab[i], hi_tab[i], s, e)) begin
				if (lo_tab[i] < ms) ms = lo_tab[i];
				if (hi_tab[i] > me) me = hi_tab[i];
			end
		for (int i = 0; i < n_used; i++) begin
			if (touches(lo_tab[i], hi_tab[i], s, e)) continue;
			if (!placed && lo_tab[i] > me) begin
				wl = {wl, ms}; wh = {wh, me}; placed = 1;
			end
			wl = {wl, lo_tab[i]}; wh = {wh, hi_tab[i]};
		end
		if (!placed) begin
			wl = {wl, ms}; wh = {wh, me};
		end
		if (wl.size() > crs_pkg::MAX_RANGES) return crs_pkg::STAT_OVERFLOW;
		foreach (wl[i]) begin
			lo_tab[i] = wl[i]; hi_tab[i] = wh[i];
		end
		n_used = wl.size();
		return crs_pkg::STAT_OK;
	endfunction

	function logic [1:0] cut_out(logic [63:0] s, logic [63:0] e);
		logic [63:0] wl[$], wh[$];
		logic [63:0] a, b;
		for (int i = 0; i < n_used; i++) begin
			a = lo_tab[i];
			b = hi_tab[i];
			if (a >= s && b <= e) continue;
			if (b < s || a > e) begin
				wl = {wl, a}; wh = {wh, b}; continue;
			end
			if (a < s) begin
				wl = {wl, a}; wh = {wh, s - 64'd1};
			end
			if (b > e) begin
				wl = {wl, e + 64'd1}; wh = {wh, b};
			end
		end
		if (wl.size() > crs_pkg::MAX_RANGES) return crs_pkg::STAT_OVERFLOW;
		foreach (wl[i]) begin
			lo_tab[i] = wl[i]; hi_tab[i] = wh[i];
		end
		n_used = wl.size();
		return crs_pkg::STAT_OK;
	endfunction

	function void note_request(logic [1:0] rt, logic [63:0] s, logic [63:0] e);
		logic [1:0] st;
		bit cov;
		cov = 0;
		if (rt == crs_pkg::REQ_READOUT) begin
			if (n_used == 0) push(crs_pkg::STAT_OK, 0, 0, 0, 1);
			for (int i = 0; i < n_used; i++)
				push(crs_pkg::STAT_OK, 0, lo_tab[i], hi_tab[i], i + 1 == n_used);
			return;
		end
		if (s > e) begin
			push(crs_pkg::STAT_BAD_SPAN, 0, 0, 0, 1);
			return;
		end
		case (rt)
			crs_pkg::REQ_ADD: st = merge_in(s, e);
			crs_pkg::REQ_REMOVE: st = cut_out(s, e);
			default: begin
				st = crs_pkg::STAT_OK;
				for (int i = 0; i < n_used; i++)
					if (s >= lo_tab[i] && e <= hi_tab[i]) cov = 1;
			end
		endcase
		push(st, cov, 0, 0, 1);
	endfunction

	function void check_result(logic [1:0] st, logic cov, logic [63:0] es,
			logic [63:0] ee, logic [4:0] cnt, logic lst);
		result_t x;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result status=%0d count=%0d", st, cnt);
			return;
		end
		x = pending.pop_front();
		if (x.status !== st || x.is_covered !== cov || x.entry_start !== es ||
				x.entry_end !== ee || x.entry_count !== cnt || x.last !== lst) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch: exp st=%0d cov=%0d es=%h ee=%h cnt=%0d last=%0d",
					x.status, x.is_covered, x.entry_start, x.entry_end, x.entry_count,
					x.last);
				$display("          got st=%0d cov=%0d es=%h ee=%h cnt=%0d last=%0d",
					st, cov, es, ee, cnt, lst);
			end
		end
	endfunction
endclass

module tb_coalesced_range_set;
	import crs_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  req_type = '0;
	val_t        span_start = '0;
	val_t        span_end = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  status;
	logic        is_covered;
	val_t        entry_start;
	val_t        entry_end;
	logic [4:0]  entry_count;
	logic        last;

	range_set_scoreboard board = new();
	longint cycles = 0;

	always #1 clk = ~clk;

	coalesced_range_set DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .span_start(span_start), .span_end(span_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .is_covered(is_covered), .entry_start(entry_start),
		.entry_end(entry_end), .entry_count(entry_count), .last(last)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: random stalls, check on every handshake
	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				board.check_result(status, is_covered, entry_start, entry_end,
					entry_count, last);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
				if (gap > 0) begin
					out_ready <= 0;
					repeat (gap) @(posedge clk);
					out_ready <= 1;
				end
			end else if (!out_ready) begin
				out_ready <= 1;
			end
		end
	end

	// valid is dropped only across an idle gap, so it gets one update per edge
	task automatic send(logic [1:0] rt, val_t s, val_t e, bit with_gap);
		int gap;
		gap = with_gap ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= rt;
		span_start <= s;
		span_end <= e;
		do @(posedge clk); while (!(in_valid && in_ready));
		board.note_request(rt, s, e);
	endtask

	function automatic val_t small_val();
		return val_t'($urandom_range(0, 200));
	endfunction

	function automatic val_t wide_val();
		return {$urandom, $urandom};
	endfunction

	initial begin
		val_t s, e, t;
		int   k;
		bit   bursty;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send(REQ_READOUT, 0, 0, 0);
		send(REQ_QUERY, 5, 5, 0);
		send(REQ_REMOVE, 1, 2, 0);
		send(REQ_ADD, 10, 20, 0);
		send(REQ_ADD, 21, 30, 0);
		send(REQ_ADD, 40, 50, 0);
		send(REQ_ADD, 0, 0, 0);
		send(REQ_ADD, '1, '1, 0);
		send(REQ_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFE, 0);
		send(REQ_QUERY, 12, 25, 0);
		send(REQ_QUERY, 25, 45, 0);
		send(REQ_REMOVE, 15, 16, 0);
		send(REQ_ADD, 9, 8, 0);
		send(REQ_REMOVE, 9, 8, 0);
		send(REQ_QUERY, 9, 8, 0);
		send(REQ_READOUT, 0, 0, 0);
		for (int i = 0; i < 12; i++) send(REQ_ADD, 100 + 4 * i, 101 + 4 * i, 0);
		send(REQ_REMOVE, 41, 41, 0);
		send(REQ_READOUT, 0, 0, 0);
		send(REQ_REMOVE, 0, '1, 0);
		send(REQ_READOUT, 0, 0, 0);
		// random: mostly small spans around a crowded table, some wide values
		for (int n = 0; n < 128; n++) begin
			bursty = (n / 20) % 2;
			k = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0) begin
				s = wide_val(); e = wide_val();
			end else begin
				s = small_val();
				e = ($urandom_range(0, 9) == 0) ? s - 1 : s + $urandom_range(0, 12);
			end
			if (s > e && $urandom_range(0, 3) != 0) begin
				t = s; s = e; e = t;
			end
			if (k < 40) send(REQ_ADD, s, e, !bursty);
			else if (k < 65) send(REQ_REMOVE, s, e, !bursty);
			else if (k < 88) send(REQ_QUERY, s, e, !bursty);
			else send(REQ_READOUT, wide_val(), wide_val(), !bursty);
			if (n == 80) begin
				// let the block drain completely before carrying on
				in_valid <= 0;
				while (board.pending.size() != 0) @(posedge clk);
			end
		end
		send(REQ_READOUT, 0, 0, 0);
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

`default_nettype wire
